/* rtl/ffa_pkg.sv */
// shared constants, field widths and codes for the first-fit heap allocator
package ffa_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int ALIGN_BYTES_DEF  = 8;

  localparam int KIND_W   = 1;
  localparam int SIZE_W   = 12;
  localparam int ADDR_W   = 12;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

/* rtl/ffa_mem.sv */
// chunk header memory, one write port and one registered read port
module ffa_mem #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 13,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [IDX_W-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ffa_ctrl.sv */
// request sequencer: size rounding, chunk walk, split, merge and free
module ffa_ctrl #(
  parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ffa_pkg::ALIGN_BYTES_DEF,
  parameter int IDX_W        = 9,
  parameter int ENT_W        = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [ffa_pkg::KIND_W-1:0]    kind,
  input  logic [ffa_pkg::SIZE_W-1:0]    request_size,
  input  logic [ffa_pkg::ADDR_W-1:0]    address,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [ffa_pkg::STATUS_W-1:0]  status,
  output logic [ffa_pkg::ADDR_W-1:0]    address_res,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output logic [ENT_W-1:0]              mem_wdata,
  output logic [IDX_W-1:0]              mem_raddr,
  input  logic [ENT_W-1:0]              mem_rdata
);

  localparam int SizeW      = ffa_pkg::SIZE_W;
  localparam int LenW       = ENT_W - 1;
  localparam int OffW       = $clog2(HEAP_BYTES + 1);
  localparam int CW         = ((OffW > SizeW + 2) ? OffW : SizeW + 2) + 1;
  localparam int GranMix    = HEADER_BYTES | ALIGN_BYTES;
  localparam int GranShift  = $clog2(GranMix & (-GranMix));
  localparam int MaxChunks  = HEAP_BYTES / HEADER_BYTES;
  localparam int CntW       = $clog2(MaxChunks + 1);
  localparam int RoundShift = SizeW + 1 + $clog2(ALIGN_BYTES);
  localparam int ProdW      = SizeW + 1 + RoundShift;
  localparam logic [RoundShift-1:0] RoundMul =
    RoundShift'(((64'd1 << RoundShift) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_R1    = 4'd2;
  localparam logic [3:0] S_R2    = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_MCHK  = 4'd6;
  localparam logic [3:0] S_SPLIT = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [CW-1:0] Hdr  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] Heap = CW'(HEAP_BYTES);

  logic [3:0]                     state, state_next;
  logic [CW-1:0]                  cur, cur_next;
  logic [CW-1:0]                  cur_len, cur_len_next;
  logic [CW-1:0]                  want, want_next;
  logic [ProdW-1:0]               prod, prod_next;
  logic [CW-1:0]                  split_off, split_off_next;
  logic [CW-1:0]                  split_len, split_len_next;
  logic [CntW-1:0]                count, count_next;
  logic [ffa_pkg::KIND_W-1:0]     op_kind, op_kind_next;
  logic [SizeW-1:0]               op_size, op_size_next;
  logic [ffa_pkg::ADDR_W-1:0]     op_addr, op_addr_next;
  logic [ffa_pkg::STATUS_W-1:0]   res_status, res_status_next;
  logic [ffa_pkg::ADDR_W-1:0]     res_addr, res_addr_next;

  logic [CW-1:0]      ent_len;
  logic               ent_free;
  logic [CW-1:0]      next_off;
  logic [CW-1:0]      payload;
  logic [CW-1:0]      merged_len;
  logic [CW-1:0]      cont_off;
  logic [CW-1:0]      rd_off;
  logic [CW-1:0]      wr_off;
  logic [CW-1:0]      rd_sh;
  logic [CW-1:0]      wr_sh;
  logic [SizeW:0]     round_in;
  logic [ProdW-1:0]   quot;
  logic               rsp_load;

  assign ent_len    = CW'(mem_rdata[LenW-1:0]);
  assign ent_free   = mem_rdata[LenW];
  assign next_off   = cur + Hdr + ent_len;
  assign payload    = cur + Hdr;
  assign merged_len = cur_len + ent_len + Hdr;
  assign round_in   = {1'b0, op_size} + (SizeW + 1)'(ALIGN_BYTES - 1);
  assign quot       = prod >> RoundShift;
  assign rsp_load   = (state == S_DONE) && (!rsp_valid || rsp_ready);
  assign req_ready  = (state == S_IDLE);

  assign rd_sh     = rd_off >> GranShift;
  assign wr_sh     = wr_off >> GranShift;
  assign mem_raddr = rd_sh[IDX_W-1:0];
  assign mem_waddr = wr_sh[IDX_W-1:0];

  // continuation point after a merge attempt
  always_comb begin
    if (ent_free) begin
      cont_off = cur + Hdr + merged_len;
    end else begin
      cont_off = cur + Hdr + cur_len;
    end
  end

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    cur_len_next    = cur_len;
    want_next       = want;
    prod_next       = prod;
    split_off_next  = split_off;
    split_len_next  = split_len;
    count_next      = count;
    op_kind_next    = op_kind;
    op_size_next    = op_size;
    op_addr_next    = op_addr;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    mem_we          = 1'b0;
    wr_off          = cur;
    mem_wdata       = {1'b0, ent_len[LenW-1:0]};
    rd_off          = cur;

    unique case (state)
      S_INIT: begin
        mem_we     = 1'b1;
        wr_off     = '0;
        mem_wdata  = {1'b1, LenW'(HEAP_BYTES - HEADER_BYTES)};
        count_next = CntW'(1);
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          op_kind_next = kind;
          op_size_next = request_size;
          op_addr_next = address;
          cur_next     = '0;
          if (kind == ffa_pkg::KIND_ALLOC) begin
            state_next = S_R1;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_R1: begin
        prod_next  = ProdW'(round_in) * ProdW'(RoundMul);
        state_next = S_R2;
      end
      S_R2: begin
        want_next  = CW'(quot[SizeW:0]) * CW'(ALIGN_BYTES);
        state_next = S_CHK;
      end
      S_FETCH: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        rd_off = next_off;
        if (op_kind == ffa_pkg::KIND_FREE) begin
          if (payload == CW'(op_addr)) begin
            mem_we          = 1'b1;
            mem_wdata       = {1'b1, ent_len[LenW-1:0]};
            res_status_next = ffa_pkg::ST_FREED;
            res_addr_next   = '0;
            state_next      = S_DONE;
          end else if (next_off == Heap) begin
            res_status_next = ffa_pkg::ST_NOT_FOUND;
            res_addr_next   = '0;
            state_next      = S_DONE;
          end else begin
            cur_next = next_off;
          end
        end else if (ent_free && ent_len == want) begin
          mem_we          = 1'b1;
          mem_wdata       = {1'b0, ent_len[LenW-1:0]};
          res_status_next = ffa_pkg::ST_ALLOCATED;
          res_addr_next   = payload[ffa_pkg::ADDR_W-1:0];
          state_next      = S_DONE;
        end else if (ent_free && ent_len >= want + Hdr && count < CntW'(MaxChunks)) begin
          mem_we          = 1'b1;
          mem_wdata       = {1'b0, want[LenW-1:0]};
          split_off_next  = payload + want;
          split_len_next  = ent_len - want - Hdr;
          res_status_next = ffa_pkg::ST_ALLOCATED;
          res_addr_next   = payload[ffa_pkg::ADDR_W-1:0];
          state_next      = S_SPLIT;
        end else if (next_off == Heap) begin
          res_status_next = ffa_pkg::ST_NO_FIT;
          res_addr_next   = '0;
          state_next      = S_DONE;
        end else if (ent_free) begin
          cur_len_next = ent_len;
          state_next   = S_MCHK;
        end else begin
          cur_next = next_off;
        end
      end
      S_MCHK: begin
        rd_off = cont_off;
        if (ent_free) begin
          count_next = count - CntW'(1);
          mem_we     = 1'b1;
          mem_wdata  = {(merged_len != want), merged_len[LenW-1:0]};
        end
        if (ent_free && merged_len == want) begin
          res_status_next = ffa_pkg::ST_ALLOCATED;
          res_addr_next   = payload[ffa_pkg::ADDR_W-1:0];
          state_next      = S_DONE;
        end else if (cont_off == Heap) begin
          res_status_next = ffa_pkg::ST_NO_FIT;
          res_addr_next   = '0;
          state_next      = S_DONE;
        end else begin
          cur_next   = cont_off;
          state_next = S_CHK;
        end
      end
      S_SPLIT: begin
        mem_we     = 1'b1;
        wr_off     = split_off;
        mem_wdata  = {1'b1, split_len[LenW-1:0]};
        count_next = count + CntW'(1);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CntW'(1);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur        <= cur_next;
    cur_len    <= cur_len_next;
    want       <= want_next;
    prod       <= prod_next;
    split_off  <= split_off_next;
    split_len  <= split_len_next;
    op_kind    <= op_kind_next;
    op_size    <= op_size_next;
    op_addr    <= op_addr_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
    if (rsp_load) begin
      status      <= res_status;
      address_res <= res_addr;
    end
  end

endmodule

/* rtl/first_fit_heap_allocator.sv */
// top level of the first-fit heap allocator
// A first-fit allocator over a byte heap of HEAP_BYTES bytes. Each chunk header (payload
// length and free flag) is kept in one synchronous memory indexed by the header's byte
// offset divided by the granule, so the chunk chain is followed by adding header and
// payload length to the current offset. After reset the block writes the initial
// heap-wide chunk in S_INIT and then raises req_ready. A request holds the block until
// its response is loaded: a free passes S_FETCH and one S_CHK per chunk visited; an
// allocate passes S_R1 and S_R2 for rounding, one S_CHK per chunk visited, one S_MCHK
// per merge attempt and S_SPLIT for a split. The memory's single read port gives one
// chunk header read per cycle. Last comes S_DONE, which moves the response into the
// output register and stretches for as long as an earlier response there is not yet
// taken; the output register holds it until taken while the next request is accepted.
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES   = ffa_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ffa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [ffa_pkg::KIND_W-1:0]    kind,
  input  logic [ffa_pkg::SIZE_W-1:0]    request_size,
  input  logic [ffa_pkg::ADDR_W-1:0]    address,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [ffa_pkg::STATUS_W-1:0]  status,
  output logic [ffa_pkg::ADDR_W-1:0]    address_res
);

  localparam int GranMix = HEADER_BYTES | ALIGN_BYTES;
  localparam int Gran    = GranMix & (-GranMix);
  localparam int Depth   = (HEAP_BYTES + Gran - 1) / Gran;
  localparam int IdxW    = $clog2(Depth);
  localparam int EntW    = $clog2(HEAP_BYTES) + 1;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [EntW-1:0] mem_wdata;
  logic [IdxW-1:0] mem_raddr;
  logic [EntW-1:0] mem_rdata;

  ffa_ctrl #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ALIGN_BYTES  (ALIGN_BYTES),
    .IDX_W        (IdxW),
    .ENT_W        (EntW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .kind         (kind),
    .request_size (request_size),
    .address      (address),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .status       (status),
    .address_res  (address_res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  ffa_mem #(
    .DEPTH (Depth),
    .WIDTH (EntW),
    .IDX_W (IdxW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

/* verif/first_fit_heap_allocator_test.sv */
// testbench for the first-fit heap allocator: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module first_fit_heap_allocator_test;

  import ffa_pkg::*;

  localparam int HEAP   = HEAP_BYTES_DEF;
  localparam int HDR    = HEADER_BYTES_DEF;
  localparam int ALIGN  = ALIGN_BYTES_DEF;
  localparam int SLOTS  = HEAP / HDR;
  localparam int RANDOM_REQUESTS = 450;

  class heap_scoreboard;

    typedef struct {
      int unsigned off;
      int unsigned len;
      bit          free;
    } chunk_t;

    typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
    } outcome_t;

    chunk_t   chunks[$];
    outcome_t outcomes[$];
    int       errors;
    int       checked;

    function new();
      chunk_t first;
      first.off  = 0;
      first.len  = HEAP - HDR;
      first.free = 1'b1;
      chunks     = {};
      chunks.push_back(first);
      outcomes   = {};
      errors     = 0;
      checked    = 0;
    endfunction

    function bit take_chunk(int unsigned size, output int unsigned payload);
      int unsigned want;
      int unsigned i;
      chunk_t      spare;
      want    = ((size + ALIGN - 1) / ALIGN) * ALIGN;
      payload = 0;
      i       = 0;
      while (i < chunks.size()) begin
        if (chunks[i].free) begin
          if (chunks[i].len == want) begin
            chunks[i].free = 1'b0;
            payload = chunks[i].off + HDR;
            return 1'b1;
          end
          if (chunks[i].len >= want + HDR && chunks.size() < SLOTS) begin
            spare.off  = chunks[i].off + HDR + want;
            spare.len  = chunks[i].len - want - HDR;
            spare.free = 1'b1;
            chunks.insert(i + 1, spare);
            chunks[i].len  = want;
            chunks[i].free = 1'b0;
            payload = chunks[i].off + HDR;
            return 1'b1;
          end
          if (i + 1 < chunks.size() && chunks[i + 1].free) begin
            chunks[i].len = chunks[i].len + chunks[i + 1].len + HDR;
            chunks.delete(i + 1);
            if (chunks[i].len == want) begin
              chunks[i].free = 1'b0;
              payload = chunks[i].off + HDR;
              return 1'b1;
            end
          end
        end
        i++;
      end
      return 1'b0;
    endfunction

    function bit release_chunk(int unsigned addr);
      foreach (chunks[i]) begin
        if (chunks[i].off + HDR == addr) begin
          chunks[i].free = 1'b1;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_request(logic [KIND_W-1:0] k, logic [SIZE_W-1:0] sz,
                               logic [ADDR_W-1:0] ad);
      outcome_t    o;
      int unsigned payload;
      o.address = '0;
      if (k == KIND_ALLOC) begin
        if (take_chunk(32'(sz), payload)) begin
          o.status  = ST_ALLOCATED;
          o.address = payload[ADDR_W-1:0];
        end else begin
          o.status = ST_NO_FIT;
        end
      end else begin
        o.status = release_chunk(32'(ad)) ? ST_FREED : ST_NOT_FOUND;
      end
      outcomes.push_back(o);
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] ad);
      outcome_t o;
      checked++;
      if (outcomes.size() == 0) begin
        $error("response with nothing outstanding: status %0d address_res %0d", st, ad);
        errors++;
        return;
      end
      o = outcomes.pop_front();
      if (st !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, st);
        errors++;
      end
      if (ad !== o.address) begin
        $error("address_res: expected %0d, actual %0d", o.address, ad);
        errors++;
      end
    endfunction

    // payload offset of a chunk in use, or of any chunk, random if none
    function logic [ADDR_W-1:0] pick_payload(bit in_use_only);
      int unsigned picks[$];
      foreach (chunks[i]) begin
        if ((!in_use_only || !chunks[i].free) && chunks[i].off + HDR < HEAP)
          picks.push_back(chunks[i].off + HDR);
      end
      if (picks.size() == 0)
        return ADDR_W'($urandom_range(HEAP - 1));
      return ADDR_W'(picks[$urandom_range(picks.size() - 1)]);
    endfunction

  endclass

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                req_valid    = 1'b0;
  logic                req_ready;
  logic [KIND_W-1:0]   kind         = KIND_ALLOC;
  logic [SIZE_W-1:0]   request_size = '0;
  logic [ADDR_W-1:0]   address      = '0;
  logic                rsp_valid;
  logic                rsp_ready    = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address_res;

  heap_scoreboard sb = new();
  bit             steady = 1'b0;

  first_fit_heap_allocator #(
    .HEAP_BYTES  (HEAP),
    .HEADER_BYTES(HDR),
    .ALIGN_BYTES (ALIGN)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .kind        (kind),
    .request_size(request_size),
    .address     (address),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .address_res (address_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(input logic [KIND_W-1:0] k, input logic [SIZE_W-1:0] sz,
                              input logic [ADDR_W-1:0] ad);
    while (!steady && $urandom_range(99) < 36) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid    <= 1'b1;
    kind         <= k;
    request_size <= sz;
    address      <= ad;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(k, sz, ad);
  endtask

  task automatic send_alloc(input logic [SIZE_W-1:0] sz);
    send_request(KIND_ALLOC, sz, ADDR_W'($urandom_range(HEAP - 1)));
  endtask

  task automatic send_free(input logic [ADDR_W-1:0] ad);
    send_request(KIND_FREE, SIZE_W'($urandom_range(HEAP - 1)), ad);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned sz;
    pick = $urandom_range(99);
    if (pick < 50) begin
      pick = $urandom_range(99);
      if (pick < 60)      sz = $urandom_range(64);
      else if (pick < 85) sz = $urandom_range(400, 65);
      else if (pick < 95) sz = $urandom_range(1500, 401);
      else                sz = $urandom_range(HEAP - 1);
      send_alloc(SIZE_W'(sz));
    end else if (pick < 87) begin
      send_free(sb.pick_payload(1'b1));
    end else if (pick < 94) begin
      send_free(sb.pick_payload(1'b0));
    end else begin
      send_free(ADDR_W'($urandom_range(HEAP - 1)));
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // freeing a chunk that is already free, unknown offsets, oversized request
    send_free(12'd16);
    send_free(12'd0);
    send_free(12'hfff);
    send_alloc(12'hfff);
    // zero size, rounding, splits down to a zero-length tail chunk
    send_alloc(12'd0);
    send_alloc(12'd1);
    send_alloc(12'd9);
    send_alloc(12'd3992);
    // zero-length last chunk: payload offset wraps to zero
    send_alloc(12'd0);
    send_alloc(12'd8);
    send_free(12'd32);
    send_free(12'd56);
    send_free(12'd88);
    send_free(12'd100);
    // merge without exact fit, walk continues
    send_alloc(12'd24);
    send_alloc(12'd40);
    send_free(12'd88);
    // merge giving an exact fit
    send_alloc(12'd3992);
    // free chunk that cannot split and has no free successor
    send_free(12'd16);
    send_alloc(12'd8);
    send_alloc(12'd4088);
    send_free(12'd2730);
    send_alloc(12'd2730);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 200 && n < 280);
      send_random_request();
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    while (sb.outcomes.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : response_sink
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held && sb.checked >= 100) begin
        // long back-pressure so the block fills up and stalls its input
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      rsp_ready <= steady || ($urandom_range(99) >= 36);
      @(posedge clk);
      if (rsp_valid && rsp_ready)
        sb.check_response(status, address_res);
    end
  end

  initial begin : watchdog
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
